>>> rtl/gga_pkg.sv
`default_nettype none

package gga_pkg;

    // ASCII codes the parser looks for.
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_G      = 8'h47;
    localparam logic [7:0] CH_P      = 8'h50;
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    // Comma count at which the altitude field is open; the next comma closes it.
    localparam logic [3:0] ALT_FIELD_COMMA = 4'd8;

    // Magnitude is held in thousandths and saturates here.
    localparam int          MAG_W      = 30;
    localparam int          OUT_W      = 31;
    localparam logic [29:0] MILLI_LIMIT = 30'd999999999;
    localparam int          MILLI_PER_UNIT = 1000;

    // Command queue between front and back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HDR_G1,
        ST_HDR_P,
        ST_HDR_G2,
        ST_HDR_G3,
        ST_HDR_A,
        ST_HDR_COMMA,
        ST_BODY
    } t_hdr_state;

    typedef enum logic {
        CMD_CHAR,
        CMD_EMIT
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind  kind;
        logic [7:0] ch;
        logic       first;
    } t_cmd_beat;

    typedef struct packed {
        logic empty;
        logic full;
    } t_queue_status;

    // Character expected in each header state; the body state maps to a comma.
    function automatic logic [7:0] hdr_expect(input t_hdr_state st);
        logic [7:0] res;
        unique case (st)
            ST_IDLE:      res = CH_DOLLAR;
            ST_HDR_G1:    res = CH_G;
            ST_HDR_P:     res = CH_P;
            ST_HDR_G2:    res = CH_G;
            ST_HDR_G3:    res = CH_G;
            ST_HDR_A:     res = CH_A;
            ST_HDR_COMMA: res = CH_COMMA;
            ST_BODY:      res = CH_COMMA;
        endcase
        return res;
    endfunction

    // Weight in thousandths of the n-th fraction digit.
    function automatic logic [6:0] frac_weight(input logic [1:0] idx);
        logic [6:0] res;
        unique case (idx)
            2'd0:    res = 7'd100;
            2'd1:    res = 7'd10;
            default: res = 7'd1;
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

>>> rtl/gga_front.sv
`default_nettype none

module gga_front #(
    parameter int MAX_FIELD_CHARS = 9
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic [7:0]           i_rx_byte,
    input  wire gga_pkg::t_queue_status i_q_status,
    output logic                      o_push,
    output gga_pkg::t_cmd_beat        o_push_beat
);
    import gga_pkg::*;

    localparam int CHAR_CNT_W = $clog2(MAX_FIELD_CHARS + 1);

    t_hdr_state            r_state, n_state;
    logic [3:0]            r_comma_cnt, n_comma_cnt;
    logic [CHAR_CNT_W-1:0] r_char_cnt, n_char_cnt;
    logic                  w_take;
    logic                  w_is_comma;
    logic                  w_match;

    assign o_in_ready = !i_q_status.full;
    assign w_take     = i_in_valid && o_in_ready;
    assign w_is_comma = (i_rx_byte == CH_COMMA);
    assign w_match    = (i_rx_byte == hdr_expect(r_state));

    // Header walk; a mismatch drops back to idle without retesting the byte.
    always_comb begin
        n_state = r_state;
        if (w_take) begin
            unique case (r_state)
                ST_IDLE:      n_state = w_match ? ST_HDR_G1    : ST_IDLE;
                ST_HDR_G1:    n_state = w_match ? ST_HDR_P     : ST_IDLE;
                ST_HDR_P:     n_state = w_match ? ST_HDR_G2    : ST_IDLE;
                ST_HDR_G2:    n_state = w_match ? ST_HDR_G3    : ST_IDLE;
                ST_HDR_G3:    n_state = w_match ? ST_HDR_A     : ST_IDLE;
                ST_HDR_A:     n_state = w_match ? ST_HDR_COMMA : ST_IDLE;
                ST_HDR_COMMA: n_state = w_match ? ST_BODY      : ST_IDLE;
                ST_BODY: begin
                    if (w_is_comma && r_comma_cnt == ALT_FIELD_COMMA) begin
                        n_state = ST_IDLE;
                    end
                end
            endcase
        end
    end

    // Commands to the back and the body counters.
    always_comb begin
        o_push            = 1'b0;
        o_push_beat.kind  = CMD_CHAR;
        o_push_beat.ch    = i_rx_byte;
        o_push_beat.first = (r_char_cnt == '0);
        n_comma_cnt       = r_comma_cnt;
        n_char_cnt        = r_char_cnt;
        if (w_take && r_state == ST_BODY) begin
            if (w_is_comma) begin
                if (r_comma_cnt == ALT_FIELD_COMMA) begin
                    o_push           = 1'b1;
                    o_push_beat.kind = CMD_EMIT;
                    n_comma_cnt      = '0;
                    n_char_cnt       = '0;
                end else begin
                    n_comma_cnt = r_comma_cnt + 4'd1;
                end
            end else if (r_comma_cnt == ALT_FIELD_COMMA &&
                         r_char_cnt < CHAR_CNT_W'(MAX_FIELD_CHARS)) begin
                o_push     = 1'b1;
                n_char_cnt = r_char_cnt + CHAR_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_comma_cnt <= '0;
            r_char_cnt  <= '0;
        end else begin
            r_state     <= n_state;
            r_comma_cnt <= n_comma_cnt;
            r_char_cnt  <= n_char_cnt;
        end
    end

endmodule

`default_nettype wire

>>> rtl/gga_queue.sv
`default_nettype none

module gga_queue (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire gga_pkg::t_cmd_beat i_push_beat,
    input  wire logic               i_pop,
    output gga_pkg::t_cmd_beat      o_head,
    output gga_pkg::t_queue_status  o_status
);
    import gga_pkg::*;

    t_cmd_beat          r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0]  r_count, n_count;

    assign o_head          = r_slot[r_rd_ptr];
    assign o_status.empty  = (r_count == '0);
    assign o_status.full   = (r_count == QCNT_W'(QUEUE_DEPTH));

    always_comb begin
        n_wr_ptr = i_push ? r_wr_ptr + QPTR_W'(1) : r_wr_ptr;
        n_rd_ptr = i_pop  ? r_rd_ptr + QPTR_W'(1) : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + QCNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_push_beat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

`default_nettype wire

>>> rtl/gga_back.sv
`default_nettype none

module gga_back #(
    parameter int FRACTION_DIGITS = 3
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire gga_pkg::t_cmd_beat    i_head,
    input  wire gga_pkg::t_queue_status i_q_status,
    output logic                       o_pop,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic signed [30:0]         o_altitude_milli
);
    import gga_pkg::*;

    logic [MAG_W-1:0]   r_mag, n_mag;
    logic               r_neg, n_neg;
    logic               r_point, n_point;
    logic [1:0]         r_frac, n_frac;
    logic               r_stopped, n_stopped;
    logic               r_out_valid, n_out_valid;
    logic [OUT_W-1:0]   r_out_data, n_out_data;

    logic               w_slot_free;
    logic               w_is_digit;
    logic [3:0]         w_digit;
    logic [MAG_W+3:0]   w_int_sum;
    logic [MAG_W:0]     w_frac_sum;
    logic [OUT_W-1:0]   w_mag_ext;

    assign w_slot_free = !r_out_valid || i_out_ready;
    assign o_pop = !i_q_status.empty && (i_head.kind == CMD_CHAR || w_slot_free);

    assign w_is_digit = (i_head.ch >= CH_ZERO) && (i_head.ch <= CH_NINE);
    assign w_digit    = 4'(i_head.ch - CH_ZERO);

    // Integer digit: shift the magnitude one decade and add the digit in units.
    assign w_int_sum = ((MAG_W+4)'(r_mag) << 3) + ((MAG_W+4)'(r_mag) << 1)
                     + (MAG_W+4)'(w_digit) * (MAG_W+4)'(MILLI_PER_UNIT);
    // Fraction digit: add it at the weight of its position.
    assign w_frac_sum = (MAG_W+1)'(r_mag)
                      + (MAG_W+1)'(w_digit) * (MAG_W+1)'(frac_weight(r_frac));

    assign w_mag_ext = OUT_W'(r_mag);

    always_comb begin
        n_mag       = r_mag;
        n_neg       = r_neg;
        n_point     = r_point;
        n_frac      = r_frac;
        n_stopped   = r_stopped;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_data  = r_out_data;
        if (o_pop) begin
            unique case (i_head.kind)
                CMD_EMIT: begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_neg ? (OUT_W'(0) - w_mag_ext) : w_mag_ext;
                    n_mag       = '0;
                    n_neg       = 1'b0;
                    n_point     = 1'b0;
                    n_frac      = '0;
                    n_stopped   = 1'b0;
                end
                CMD_CHAR: begin
                    if (!r_stopped) begin
                        priority if (w_is_digit) begin
                            if (!r_point) begin
                                n_mag = (w_int_sum > (MAG_W+4)'(MILLI_LIMIT))
                                      ? MILLI_LIMIT : MAG_W'(w_int_sum);
                            end else if (int'(r_frac) < FRACTION_DIGITS) begin
                                n_mag  = (w_frac_sum > (MAG_W+1)'(MILLI_LIMIT))
                                       ? MILLI_LIMIT : MAG_W'(w_frac_sum);
                                n_frac = r_frac + 2'd1;
                            end
                        end else if (i_head.ch == CH_DOT && !r_point) begin
                            n_point = 1'b1;
                        end else if (i_head.first &&
                                     (i_head.ch == CH_PLUS || i_head.ch == CH_MINUS)) begin
                            n_neg = (i_head.ch == CH_MINUS);
                        end else begin
                            n_stopped = 1'b1;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mag       <= '0;
            r_neg       <= 1'b0;
            r_point     <= 1'b0;
            r_frac      <= '0;
            r_stopped   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_mag       <= n_mag;
            r_neg       <= n_neg;
            r_point     <= n_point;
            r_frac      <= n_frac;
            r_stopped   <= n_stopped;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
    end

    assign o_out_valid      = r_out_valid;
    assign o_altitude_milli = $signed(r_out_data);

endmodule

`default_nettype wire

>>> rtl/gga_altitude_extractor.sv
`default_nettype none

// Channel   Direction  Handshake               Payload
// input     in         i_in_valid/o_in_ready   i_rx_byte        (8 bits, ASCII)
// result    out        o_out_valid/i_out_ready o_altitude_milli (31 bits, signed)
//
// One byte is accepted per cycle while the command queue has room.
// A result is written to the output register when the closing-comma command
// of the altitude field leaves the queue, and then holds until it is taken.
// Reset (i_rst_n low at a clock edge) returns the parser to idle and empties
// the queue and the output register.
// A stalled output only blocks the back end on the closing-comma command; the
// four-beat queue lets the front keep taking bytes until it fills.

module gga_altitude_extractor #(
    parameter int MAX_FIELD_CHARS = 9,
    parameter int FRACTION_DIGITS = 3
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire logic [7:0]    i_rx_byte,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output logic signed [30:0] o_altitude_milli
);
    import gga_pkg::*;

    // The front matches the sentence header and counts commas. It only hands
    // over work that affects the result: one command per captured altitude
    // character and one for the comma that closes the field.
    logic          w_push;
    t_cmd_beat     w_push_beat;
    logic          w_pop;
    t_cmd_beat     w_head;
    t_queue_status w_q_status;

    gga_front #(
        .MAX_FIELD_CHARS(MAX_FIELD_CHARS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_rx_byte   (i_rx_byte),
        .i_q_status  (w_q_status),
        .o_push      (w_push),
        .o_push_beat (w_push_beat)
    );

    // Commands wait here in order, so the numeric state in the back always
    // sees the characters of a field before the comma that closes it.
    gga_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_beat (w_push_beat),
        .i_pop       (w_pop),
        .o_head      (w_head),
        .o_status    (w_q_status)
    );

    // The back builds the magnitude in thousandths with saturation, tracks
    // sign, decimal point and the stop condition, and owns the result register.
    gga_back #(
        .FRACTION_DIGITS(FRACTION_DIGITS)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_head           (w_head),
        .i_q_status       (w_q_status),
        .o_pop            (w_pop),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_altitude_milli (o_altitude_milli)
    );

endmodule

`default_nettype wire

>>> rtl/gga_port_checker.sv
`default_nettype none

module gga_port_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_ready,
    input wire logic [7:0]  i_rx_byte,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic [30:0] o_altitude_milli
);

    // Reset empties the output register.
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // A result that is not taken stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_altitude_milli))
        else $error("stalled result changed");

    // The magnitude saturates below one million metres.
    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ($signed(o_altitude_milli) <= 31'sd999999999) &&
                        ($signed(o_altitude_milli) >= -31'sd999999999))
        else $error("result out of range");

    // The queue can only fill while a result waits on the output.
    a_full_needs_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_in_ready) |-> $past(o_out_valid && !i_out_ready))
        else $error("input stalled without an output stall");

    // A byte that is offered but not taken stays on the input unchanged.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_rx_byte))
        else $error("stalled input byte changed");

endmodule

bind gga_altitude_extractor gga_port_checker u_port_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_ready       (o_in_ready),
    .i_rx_byte        (i_rx_byte),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_altitude_milli (o_altitude_milli)
);

`default_nettype wire

>>> tb/altitude_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the altitude extractor, keeps its own copy of the
// parser state, and compares every result beat with the oldest altitude due.
module altitude_checker #(
    parameter int MAX_FIELD_CHARS = 9,
    parameter int FRACTION_DIGITS = 3
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic          i_in_ready,
    input  wire logic [7:0]    i_rx_byte,
    input  wire logic          i_out_valid,
    input  wire logic          i_out_ready,
    input  wire logic [30:0]   i_altitude_milli,
    output int                 o_pending,
    output int                 o_results,
    output int                 o_errors
);

    import gga_pkg::*;

    t_hdr_state  hdr_state;
    logic [3:0]  comma_count;
    logic [3:0]  field_chars;
    logic [29:0] magnitude;
    logic        negative;
    logic        point_seen;
    logic [1:0]  fraction_digits;
    logic        stopped;

    logic [30:0] altitudes_due [$];

    function automatic logic [7:0] header_byte(input t_hdr_state st);
        logic [7:0] ch;
        case (st)
            ST_IDLE:   ch = CH_DOLLAR;
            ST_HDR_P:  ch = CH_P;
            ST_HDR_A:  ch = CH_A;
            ST_HDR_G1,
            ST_HDR_G2,
            ST_HDR_G3: ch = CH_G;
            default:   ch = CH_COMMA;
        endcase
        return ch;
    endfunction

    function automatic logic [29:0] clamp_milli(input logic [63:0] v);
        return (v > 64'(MILLI_LIMIT)) ? MILLI_LIMIT : v[29:0];
    endfunction

    task automatic clear_parser();
        hdr_state       = ST_IDLE;
        comma_count     = '0;
        field_chars     = '0;
        magnitude       = '0;
        negative        = 1'b0;
        point_seen      = 1'b0;
        fraction_digits = '0;
        stopped         = 1'b0;
    endtask

    task automatic report_mismatch(input string what);
        $display("checker: %s", what);
        o_errors++;
    endtask

    // One character of the altitude field, inside the capture window.
    task automatic fold_altitude_char(input logic [7:0] ch);
        logic        first;
        logic [63:0] digit;
        logic [63:0] wide;
        logic [63:0] weight;
        first       = (field_chars == 4'd0);
        field_chars = field_chars + 4'd1;
        if (!stopped) begin
            if (ch >= CH_ZERO && ch <= CH_NINE) begin
                digit = 64'(ch - CH_ZERO);
                wide  = 64'(magnitude);
                if (!point_seen) begin
                    magnitude = clamp_milli(wide * 64'd10 + digit * 64'(MILLI_PER_UNIT));
                end else if (fraction_digits < FRACTION_DIGITS) begin
                    case (fraction_digits)
                        2'd0:    weight = 64'd100;
                        2'd1:    weight = 64'd10;
                        default: weight = 64'd1;
                    endcase
                    magnitude       = clamp_milli(wide + digit * weight);
                    fraction_digits = fraction_digits + 2'd1;
                end
            end else if (ch == CH_DOT && !point_seen) begin
                point_seen = 1'b1;
            end else if (first && (ch == CH_PLUS || ch == CH_MINUS)) begin
                negative = (ch == CH_MINUS);
            end else begin
                stopped = 1'b1;
            end
        end
    endtask

    task automatic parse_rx_byte(input logic [7:0] ch);
        logic [30:0] mag31;
        if (hdr_state != ST_BODY) begin
            if (ch == header_byte(hdr_state)) begin
                hdr_state = t_hdr_state'(hdr_state + 3'd1);
            end else begin
                hdr_state = ST_IDLE;
            end
        end else if (ch == CH_COMMA) begin
            comma_count = comma_count + 4'd1;
            if (comma_count > ALT_FIELD_COMMA) begin
                mag31 = {1'b0, magnitude};
                altitudes_due.push_back(negative ? -mag31 : mag31);
                clear_parser();
            end
        end else if (comma_count == ALT_FIELD_COMMA && field_chars < MAX_FIELD_CHARS) begin
            fold_altitude_char(ch);
        end
    endtask

    task automatic check_altitude(input logic [30:0] got);
        logic [30:0] want;
        if (altitudes_due.size() == 0) begin
            report_mismatch($sformatf("altitude %0d arrived with none due", $signed(got)));
        end else begin
            want = altitudes_due.pop_front();
            if (got !== want) begin
                report_mismatch($sformatf("altitude_milli %0d, expected %0d",
                                          $signed(got), $signed(want)));
            end
        end
        o_results++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_parser();
            altitudes_due.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                check_altitude(i_altitude_milli);
            end
            if (i_in_valid && i_in_ready) begin
                parse_rx_byte(i_rx_byte);
            end
        end
        o_pending = altitudes_due.size();
    end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

    import gga_pkg::*;

    localparam int MAX_FIELD_CHARS = 9;
    localparam int FRACTION_DIGITS = 3;

    // Generous cycle budget for the whole run.
    localparam int LIMIT_CYCLES  = 500000;
    // Least number of counted bytes sent in each idling phase.
    localparam int PHASE_BYTES   = 180;
    // Extra wait after the last altitude has drained.
    localparam int DRAIN_CYCLES  = 20;

    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic [7:0]  rx_byte   = 8'h00;
    logic        out_ready = 1'b0;
    wire         in_ready;
    wire         out_valid;
    wire [30:0]  altitude_milli;

    int pending;
    int results;
    int errors;

    // Chance, in percent, that the sender or the receiver sits out a cycle.
    int send_idle_pct = 38;
    int recv_idle_pct = 63;

    int cycle_count;
    int field_bytes_sent;
    int sentences;

    // Bytes of the sentence being assembled, sent in order by send_queued.
    logic [7:0] pending_text [$];

    gga_altitude_extractor #(
        .MAX_FIELD_CHARS (MAX_FIELD_CHARS),
        .FRACTION_DIGITS (FRACTION_DIGITS)
    ) u_top (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_rx_byte        (rx_byte),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_altitude_milli (altitude_milli)
    );

    altitude_checker #(
        .MAX_FIELD_CHARS (MAX_FIELD_CHARS),
        .FRACTION_DIGITS (FRACTION_DIGITS)
    ) u_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_ready       (in_ready),
        .i_rx_byte        (rx_byte),
        .i_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .i_altitude_milli (altitude_milli),
        .o_pending        (pending),
        .o_results        (results),
        .o_errors         (errors)
    );

    initial begin
        forever #10 clk = ~clk;
    end

    // The receiver decides afresh at every falling edge whether it takes a beat.
    always @(negedge clk) begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("cycle limit reached with %0d altitudes still due", pending);
            $display("testbench: errors");
            $finish;
        end
    end

    // Offers one byte and returns at the falling edge after it was accepted.
    // Valid stays high on return so back-to-back beats need no gap.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            rx_byte  <= 8'($urandom);
            @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    // Sends everything assembled so far; its bytes count toward the phase length
    // only when counted is set.
    task automatic send_queued(input bit counted);
        logic [7:0] b;
        while (pending_text.size() != 0) begin
            b = pending_text.pop_front();
            send_byte(b);
            if (counted) field_bytes_sent++;
        end
    endtask

    // Holds the input idle until every altitude in flight has come out.
    task automatic wait_for_drain();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) pending_text.push_back(s[i]);
    endtask

    function automatic logic [7:0] random_digit();
        logic [7:0] d;
        d = CH_ZERO + 8'($urandom_range(0, 9));
        return d;
    endfunction

    // Filler for the fields ahead of the altitude: mostly digits, some letters
    // and points, and now and then any byte value at all.
    function automatic logic [7:0] filler_char();
        logic [7:0] c;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: c = random_digit();
            6:                c = CH_DOT;
            7, 8:             c = 8'h41 + 8'($urandom_range(0, 25));
            default:          c = 8'($urandom);
        endcase
        return c;
    endfunction

    task automatic add_filler_field();
        repeat ($urandom_range(0, 3)) pending_text.push_back(filler_char());
        pending_text.push_back(CH_COMMA);
    endtask

    // Altitude text: mostly well-formed numbers, with runs of digit, sign and point
    // characters, arbitrary bytes, digit runs long enough to saturate, and
    // empty fields mixed in. The closing comma is added by the caller.
    task automatic add_altitude_field();
        string marks;
        int    kind;
        marks = "0123456789.+-";
        kind  = $urandom_range(0, 9);
        if (kind <= 5) begin
            case ($urandom_range(0, 3))
                0:       pending_text.push_back(CH_MINUS);
                1:       pending_text.push_back(CH_PLUS);
                default: ;
            endcase
            repeat ($urandom_range(0, 6)) pending_text.push_back(random_digit());
            if ($urandom_range(0, 3) != 0) begin
                pending_text.push_back(CH_DOT);
                repeat ($urandom_range(0, 5)) pending_text.push_back(random_digit());
            end
        end else if (kind == 6) begin
            repeat ($urandom_range(0, 11)) pending_text.push_back(marks[$urandom_range(0, 12)]);
        end else if (kind == 7) begin
            repeat ($urandom_range(0, 10)) pending_text.push_back(8'($urandom));
        end else if (kind == 8) begin
            if ($urandom_range(0, 1) != 0) pending_text.push_back(CH_MINUS);
            repeat ($urandom_range(8, 12)) pending_text.push_back(random_digit());
        end
    endtask

    // Checksum and line end; the parser is back in idle by then.
    task automatic add_tail();
        add_text("M,,M,,*");
        pending_text.push_back(8'h30 + 8'($urandom_range(0, 9)));
        pending_text.push_back(8'h41 + 8'($urandom_range(0, 5)));
        pending_text.push_back(CH_CR);
        pending_text.push_back(CH_LF);
    endtask

    task automatic good_sentence();
        add_text("$GPGGA,");
        repeat (8) add_filler_field();
        add_altitude_field();
        pending_text.push_back(CH_COMMA);
        send_queued(1'b1);
        add_tail();
        send_queued(1'b0);
        sentences++;
    endtask

    // Broken sequences: a header that goes wrong part way, a sentence cut off
    // before its altitude closes (its commas carry into what follows), or noise.
    task automatic broken_sentence();
        string      hdr;
        int         cut;
        logic [7:0] wrong;
        hdr = "$GPGGA,";
        case ($urandom_range(0, 2))
            0: begin
                cut = $urandom_range(0, 6);
                for (int i = 0; i < cut; i++) pending_text.push_back(hdr[i]);
                wrong = 8'($urandom);
                if (wrong == hdr[cut]) wrong = wrong ^ 8'h01;
                pending_text.push_back(wrong);
                repeat ($urandom_range(0, 9)) add_filler_field();
                send_queued(1'b1);
            end
            1: begin
                add_text(hdr);
                repeat ($urandom_range(0, 8)) add_filler_field();
                if ($urandom_range(0, 1) != 0) add_altitude_field();
                pending_text.push_back(CH_CR);
                pending_text.push_back(CH_LF);
                send_queued(1'b1);
            end
            default: begin
                repeat ($urandom_range(1, 8)) pending_text.push_back(8'($urandom));
                send_queued(1'b0);
            end
        endcase
    endtask

    task automatic random_step();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
            good_sentence();
        end else begin
            broken_sentence();
        end
        // Now and then the sender holds off until the pipeline is empty.
        if ($urandom_range(0, 39) == 0) wait_for_drain();
    endtask

    // A sentence with empty leading fields and the given altitude text.
    task automatic directed_altitude(input string alt);
        add_text("$GPGGA,,,,,,,,,");
        add_text(alt);
        pending_text.push_back(CH_COMMA);
        send_queued(1'b1);
        sentences++;
    endtask

    initial begin
        int phase_start;

        // Synchronous reset, released on a falling edge.
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part: empty and sign-only fields, negative zero, saturation,
        // the capture limit, extra fraction digits, a second point, a misplaced
        // sign and a plain invalid character.
        directed_altitude("");
        directed_altitude("-");
        directed_altitude(".");
        directed_altitude("-0.000");
        directed_altitude("+7");
        directed_altitude("999999999");
        directed_altitude("-99999.999");
        directed_altitude("12.34567");
        directed_altitude("1.2.3");
        directed_altitude("5+3");
        directed_altitude("12a34");
        directed_altitude("1234567890");

        // Header mismatches: a wrong letter, and a doubled dollar sign whose
        // second copy is not taken as a fresh start. Extreme bytes in idle too.
        pending_text.push_back(8'h00);
        pending_text.push_back(8'hFF);
        add_text("$GPGGB,,,,,,,,,1,");
        add_text("$$GPGGA,,,,,,,,,5,");
        send_queued(1'b1);

        // Body bytes that only count as non-commas, then an altitude ended by 0xFF.
        add_text("$GPGGA,");
        pending_text.push_back(CH_DOLLAR);
        pending_text.push_back(CH_COMMA);
        pending_text.push_back(8'h00);
        pending_text.push_back(8'hFF);
        pending_text.push_back(CH_COMMA);
        pending_text.push_back(CH_CR);
        pending_text.push_back(CH_LF);
        add_text(",,,,,,4");
        pending_text.push_back(8'hFF);
        add_text("5,");
        send_queued(1'b1);
        wait_for_drain();

        // Three idling mixes: sender-heavy, receiver-heavy, then none at all.
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 38;
                    recv_idle_pct = 63;
                end
                1: begin
                    send_idle_pct = 63;
                    recv_idle_pct = 38;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            phase_start = field_bytes_sent;
            while (field_bytes_sent - phase_start < PHASE_BYTES) random_step();
            wait_for_drain();
        end

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("run covered %0d sentences and %0d parsed bytes; %0d altitudes compared",
                 sentences, field_bytes_sent, results);
        $display("under sender-heavy, receiver-heavy and back-to-back traffic");
        if (errors == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule

>>> gga_altitude_extractor.f
rtl/gga_pkg.sv
rtl/gga_front.sv
rtl/gga_queue.sv
rtl/gga_back.sv
rtl/gga_altitude_extractor.sv
rtl/gga_port_checker.sv
tb/altitude_checker.sv
tb/testbench.sv
